@@ hdl/cbsm_pkg.sv @@
`timescale 1ns / 1ps

package cbsm_pkg;

	localparam int ImageBytesDefault   = 16384;
	localparam int CartRamBytesDefault = 256;
	localparam int ConsoleRamBytes     = 128;
	localparam int ConsoleAw           = 7;

	localparam int ActionW   = 2;
	localparam int AddressW  = 13;
	localparam int DataW     = 8;
	localparam int ImageIdxW = 14;
	localparam int OffsetW   = 12;
	localparam int CfgIndexW = 1;
	localparam int CfgDataW  = 3;

	typedef logic [ActionW-1:0]   action_t;
	typedef logic [AddressW-1:0]  address_t;
	typedef logic [DataW-1:0]     data_t;
	typedef logic [ImageIdxW-1:0] image_idx_t;
	typedef logic [OffsetW-1:0]   offset_t;
	typedef logic [2:0]           mode_t;

	localparam action_t ACT_READ  = 2'd0;
	localparam action_t ACT_WRITE = 2'd1;
	localparam action_t ACT_LOAD  = 2'd2;

	localparam mode_t MODE_4K     = 3'd0;
	localparam mode_t MODE_16K    = 3'd1;
	localparam mode_t MODE_8K     = 3'd2;
	localparam mode_t MODE_12K    = 3'd3;
	localparam mode_t MODE_SLICED = 3'd4;

	localparam logic [CfgIndexW-1:0] REG_BANK_MODE = 1'd0;
	localparam logic [CfgIndexW-1:0] REG_SUPERCHIP = 1'd1;

	localparam offset_t HOT_16K_LO   = 12'hFF6;
	localparam offset_t HOT_16K_HI   = 12'hFF9;
	localparam offset_t HOT_8K_LO    = 12'hFF8;
	localparam offset_t HOT_12K_HI   = 12'hFFA;
	localparam offset_t HOT_SLICE_LO = 12'hFE0;
	localparam offset_t HOT_SLICE_HI = 12'hFF7;

	localparam logic [1:0] SRC_NONE    = 2'd0;
	localparam logic [1:0] SRC_IMAGE   = 2'd1;
	localparam logic [1:0] SRC_CONSOLE = 2'd2;
	localparam logic [1:0] SRC_CART    = 2'd3;

	typedef struct packed {
		logic       valid;
		logic [1:0] src;
		logic       passed;
	} pend_t;

endpackage

@@ hdl/cbsm_req_if.sv @@
`timescale 1ns / 1ps

interface cbsm_req_if;
	logic                  valid;
	logic                  ready;
	cbsm_pkg::action_t    action;
	cbsm_pkg::address_t   address;
	cbsm_pkg::data_t      data;
	cbsm_pkg::image_idx_t image_index;

	modport source (output valid, action, address, data, image_index, input ready);
	modport sink (input valid, action, address, data, image_index, output ready);
endinterface

@@ hdl/cbsm_rsp_if.sv @@
`timescale 1ns / 1ps

interface cbsm_rsp_if;
	logic             valid;
	logic             ready;
	cbsm_pkg::data_t read_data;
	logic             passed_on;

	modport source (output valid, read_data, passed_on, input ready);
	modport sink (input valid, read_data, passed_on, output ready);
endinterface

@@ hdl/cbsm_ram.sv @@
`timescale 1ns / 1ps

module cbsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ hdl/cartridge_bank_switch_mapper.sv @@
`timescale 1ns / 1ps
// channel  dir  handshake      payload
// req      in   valid/ready    action, address, data, image_index
// rsp      out  valid/ready    read_data, passed_on
// cfg      in   cfg_we         cfg_index, cfg_data
//
// One request per cycle while the response side is not stalled; after acceptance a response
// passes through the synchronous memory read and then the output register.
// Bank selects update at acceptance, so the next request sees the new mapping.
// Reset clears bank selects and config; the memories are not cleared.
// A stalled response holds the read stage, and req.ready drops once both are full.

module cartridge_bank_switch_mapper #(
	parameter int IMAGE_BYTES    = cbsm_pkg::ImageBytesDefault,
	parameter int CART_RAM_BYTES = cbsm_pkg::CartRamBytesDefault
) (
	input  logic                             clk,
	input  logic                             arst_n,
	cbsm_req_if.sink                         req,
	cbsm_rsp_if.source                       rsp,
	input  logic                             cfg_we,
	input  logic [cbsm_pkg::CfgIndexW-1:0]   cfg_index,
	input  logic [cbsm_pkg::CfgDataW-1:0]    cfg_data
);
	import cbsm_pkg::*;

	localparam int ImgAw  = $clog2(IMAGE_BYTES);
	localparam int CartAw = $clog2(CART_RAM_BYTES);

	mode_t      mode_q;
	logic       sc_q;
	logic [1:0] big_bank_q;
	logic [2:0] slice_q [0:2];

	pend_t      pend_s1;
	logic       out_valid_q;
	data_t      out_data_q;
	logic       out_passed_q;

	logic       accept;
	logic       s1_move;
	offset_t    off;

	logic [ImageIdxW-1:0] win_addr;
	logic [ImageIdxW-1:0] img_addr;
	logic [7:0]           cart_addr;
	logic                 sc_rd;
	logic                 img_re, img_we, con_re, con_we, cart_re, cart_we;
	logic                 img_ok, cart_ok;
	logic                 hot;
	logic [1:0]           src;
	logic                 passed;

	data_t img_rdata, con_rdata, cart_rdata;

	assign s1_move   = pend_s1.valid && (!out_valid_q || rsp.ready);
	assign req.ready = !pend_s1.valid || s1_move;
	assign accept    = req.valid && req.ready;
	assign off       = req.address[OffsetW-1:0];

	always_comb begin
		case (mode_q)
			MODE_16K, MODE_8K, MODE_12K: win_addr = {big_bank_q, off};
			MODE_SLICED: begin
				if (off[11:10] == 2'd3) begin
					win_addr = {4'd7, off[9:0]};
				end else begin
					win_addr = {1'b0, slice_q[off[11:10]], off[9:0]};
				end
			end
			default: win_addr = {2'b00, off};
		endcase
	end

	assign img_addr  = (req.action == ACT_LOAD) ? req.image_index : win_addr;
	assign sc_rd     = sc_q && req.action == ACT_READ && off[11:7] == 5'b00001;
	assign cart_addr = sc_rd ? {1'b0, off[6:0]} : off[7:0];

	assign img_ok  = {1'b0, img_addr} < (ImageIdxW+1)'(IMAGE_BYTES);
	assign cart_ok = {1'b0, cart_addr} < 9'(CART_RAM_BYTES);

	always_comb begin
		img_re    = 1'b0;
		img_we    = 1'b0;
		con_re    = 1'b0;
		con_we    = 1'b0;
		cart_re   = 1'b0;
		cart_we   = 1'b0;
		hot       = 1'b0;
		src       = SRC_NONE;
		passed    = 1'b0;
		if (req.action == ACT_LOAD) begin
			img_we = img_ok;
		end else if (req.action == ACT_READ || req.action == ACT_WRITE) begin
			if (req.address[12]) begin
				if (req.action == ACT_READ) begin
					if (sc_rd) begin
						cart_re = 1'b1;
						src     = cart_ok ? SRC_CART : SRC_NONE;
					end else if (mode_q == MODE_12K && off[11:8] == 4'h1) begin
						cart_re = 1'b1;
						src     = cart_ok ? SRC_CART : SRC_NONE;
					end else begin
						img_re = 1'b1;
						src    = img_ok ? SRC_IMAGE : SRC_NONE;
						hot    = 1'b1;
					end
				end else begin
					if ((mode_q == MODE_12K && off[11:8] == 4'h0) ||
					    (sc_q && off[11:7] == 5'b00000)) begin
						cart_we = cart_ok;
					end
					hot = 1'b1;
				end
			end else if (req.address[9] == 1'b0 && req.address[7]) begin
				if (req.action == ACT_READ) begin
					con_re = 1'b1;
					src    = SRC_CONSOLE;
				end else begin
					con_we = 1'b1;
				end
			end else begin
				passed = 1'b1;
			end
		end
	end

	cbsm_ram #(.WIDTH(DataW), .DEPTH(IMAGE_BYTES)) u_image (
		.clk(clk), .we(accept && img_we), .waddr(img_addr[ImgAw-1:0]), .wdata(req.data),
		.re(accept && img_re), .raddr(img_addr[ImgAw-1:0]), .rdata(img_rdata)
	);

	cbsm_ram #(.WIDTH(DataW), .DEPTH(ConsoleRamBytes)) u_console (
		.clk(clk), .we(accept && con_we), .waddr(req.address[ConsoleAw-1:0]),
		.wdata(req.data), .re(accept && con_re), .raddr(req.address[ConsoleAw-1:0]),
		.rdata(con_rdata)
	);

	cbsm_ram #(.WIDTH(DataW), .DEPTH(CART_RAM_BYTES)) u_cart (
		.clk(clk), .we(accept && cart_we), .waddr(cart_addr[CartAw-1:0]), .wdata(req.data),
		.re(accept && cart_re), .raddr(cart_addr[CartAw-1:0]), .rdata(cart_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_4K;
			sc_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BANK_MODE: mode_q <= cfg_data;
				REG_SUPERCHIP: sc_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			big_bank_q <= '0;
			slice_q    <= '{default: '0};
		end else if (accept && hot) begin
			case (mode_q)
				MODE_16K: begin
					if (off inside {[HOT_16K_LO:HOT_16K_HI]}) begin
						big_bank_q <= 2'(off - HOT_16K_LO);
					end
				end
				MODE_8K: begin
					if (off inside {[HOT_8K_LO:HOT_16K_HI]}) begin
						big_bank_q <= 2'(off - HOT_8K_LO);
					end
				end
				MODE_12K: begin
					if (off inside {[HOT_8K_LO:HOT_12K_HI]}) begin
						big_bank_q <= 2'(off - HOT_8K_LO);
					end
				end
				MODE_SLICED: begin
					if (off inside {[HOT_SLICE_LO:HOT_SLICE_HI]}) begin
						slice_q[off[4:3]] <= off[2:0];
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				pend_s1 <= '{valid: 1'b1, src: src, passed: passed};
			end else if (s1_move) begin
				pend_s1.valid <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_passed_q <= pend_s1.passed;
			case (pend_s1.src)
				SRC_IMAGE:   out_data_q <= img_rdata;
				SRC_CONSOLE: out_data_q <= con_rdata;
				SRC_CART:    out_data_q <= cart_rdata;
				default:     out_data_q <= '0;
			endcase
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.read_data = out_data_q;
	assign rsp.passed_on = out_passed_q;
endmodule

@@ verif/tb_cartridge_bank_switch_mapper.sv @@
`timescale 1ns / 1ps

module tb_cartridge_bank_switch_mapper;
	import cbsm_pkg::*;

	localparam action_t ACT_RESERVED = 2'd3;
	localparam mode_t MODE_UNUSED = 3'd7;
	localparam offset_t SC_READ_BASE = 12'h080;
	localparam offset_t RAM_READ_BASE = 12'h100;
	localparam offset_t RAM_READ_END = 12'h200;
	localparam address_t CON_MASK = 13'h0280;
	localparam address_t CON_HIT = 13'h0080;
	localparam int SETTLE_CYCLES = 6;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int NUM_PHASES = 10;
	localparam int PHASE_ITEMS = 90;

	typedef logic [2:0][2:0] slice_set_t;
	typedef enum logic [2:0] {ST_NONE, ST_PASS, ST_IMAGE, ST_CONSOLE, ST_CART} store_t;
	typedef enum logic [1:0] {ENT_ACCESS, ENT_CONFIG, ENT_DRAIN} entry_kind_t;

	typedef struct packed {
		entry_kind_t kind;
		action_t action;
		address_t address;
		data_t data;
		image_idx_t image_index;
		logic [CfgIndexW-1:0] reg_index;
		logic [CfgDataW-1:0] reg_value;
		logic [4:0] gap;
	} bus_entry_t;

	typedef struct packed {
		data_t read_data;
		logic passed_on;
	} bus_reply_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CfgIndexW-1:0] cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	cbsm_req_if req_ch ();
	cbsm_rsp_if rsp_ch ();

	cartridge_bank_switch_mapper uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// mapper state as the checker sees it
	data_t img_mem [ImageBytesDefault];
	data_t con_mem [ConsoleRamBytes];
	data_t crt_mem [CartRamBytesDefault];
	logic [1:0] sel_bank;
	slice_set_t sel_slices;
	mode_t cfg_mode;
	logic cfg_sc;

	// shadow kept while building stimulus, to never read unwritten memory
	bit img_known [ImageBytesDefault];
	bit con_known [ConsoleRamBytes];
	bit crt_known [CartRamBytesDefault];
	logic [1:0] gen_bank;
	slice_set_t gen_slices;
	mode_t gen_mode;
	logic gen_sc;
	bit quiet_sender;

	bus_entry_t bus_requests [$];
	bus_reply_t bus_replies_due [$];
	bus_entry_t head;

	int gap_left;
	int settle;
	int stall_left;
	int quiet_cycles;
	int mismatches;
	int replies_seen;
	int n_loads, n_image_reads, n_console, n_cart, n_passed, n_switches;

	function automatic image_idx_t map_window(mode_t m, logic [1:0] bank, slice_set_t sl,
			offset_t off);
		logic [1:0] part;
		part = off[11:10];
		case (m)
			MODE_16K, MODE_8K, MODE_12K: return {bank, off};
			MODE_SLICED: begin
				if (part == 2'd3)
					return {1'b0, 3'd7, off[9:0]};
				return {1'b0, sl[part], off[9:0]};
			end
			default: return {2'b00, off};
		endcase
	endfunction

	function automatic void apply_hotspot(mode_t m, offset_t off, inout logic [1:0] bank,
			inout slice_set_t sl);
		offset_t rel;
		rel = off - HOT_SLICE_LO;
		case (m)
			MODE_16K: if (off >= HOT_16K_LO && off <= HOT_16K_HI) bank = 2'(off - HOT_16K_LO);
			MODE_8K: if (off >= HOT_8K_LO && off <= HOT_16K_HI) bank = 2'(off - HOT_8K_LO);
			MODE_12K: if (off >= HOT_8K_LO && off <= HOT_12K_HI) bank = 2'(off - HOT_8K_LO);
			MODE_SLICED: if (off >= HOT_SLICE_LO && off <= HOT_SLICE_HI) sl[rel[4:3]] = off[2:0];
			default: ;
		endcase
	endfunction

	// where a bus access lands; hot marks accesses that may switch banks
	function automatic store_t route(mode_t m, logic sc, logic [1:0] bank, slice_set_t sl,
			action_t act, address_t addr, output int idx, output logic hot);
		offset_t off;
		off = addr[11:0];
		idx = 0;
		hot = 1'b0;
		if (act != ACT_READ && act != ACT_WRITE)
			return ST_NONE;
		if (addr[12]) begin
			if (act == ACT_READ) begin
				if (sc && off >= SC_READ_BASE && off < RAM_READ_BASE) begin
					idx = off[6:0];
					return ST_CART;
				end
				if (m == MODE_12K && off >= RAM_READ_BASE && off < RAM_READ_END) begin
					idx = off[7:0];
					return ST_CART;
				end
				hot = 1'b1;
				idx = map_window(m, bank, sl, off);
				return ST_IMAGE;
			end
			hot = 1'b1;
			idx = off;
			if ((m == MODE_12K && off < RAM_READ_BASE) || (sc && off < SC_READ_BASE))
				return ST_CART;
			return ST_NONE;
		end
		if ((addr & CON_MASK) == CON_HIT) begin
			idx = addr[6:0];
			return ST_CONSOLE;
		end
		return ST_PASS;
	endfunction

	function automatic bus_reply_t serve_access(bus_entry_t e);
		bus_reply_t r;
		store_t st;
		int idx;
		logic hot;
		logic [1:0] old_bank;
		slice_set_t old_slices;
		r = '0;
		if (e.action == ACT_LOAD) begin
			img_mem[e.image_index] = e.data;
			n_loads++;
			return r;
		end
		st = route(cfg_mode, cfg_sc, sel_bank, sel_slices, e.action, e.address, idx, hot);
		case (st)
			ST_PASS: begin
				r.passed_on = 1'b1;
				n_passed++;
			end
			ST_IMAGE: begin
				r.read_data = img_mem[idx];
				n_image_reads++;
			end
			ST_CONSOLE: begin
				if (e.action == ACT_READ)
					r.read_data = con_mem[idx];
				else
					con_mem[idx] = e.data;
				n_console++;
			end
			ST_CART: begin
				if (e.action == ACT_READ)
					r.read_data = crt_mem[idx];
				else
					crt_mem[idx] = e.data;
				n_cart++;
			end
			default: ;
		endcase
		if (hot) begin
			old_bank = sel_bank;
			old_slices = sel_slices;
			apply_hotspot(cfg_mode, e.address[11:0], sel_bank, sel_slices);
			if (old_bank != sel_bank || old_slices != sel_slices)
				n_switches++;
		end
		return r;
	endfunction

	function automatic logic [4:0] draw_gap();
		if (quiet_sender || $urandom_range(0, 1))
			return 5'd0;
		return 5'($urandom_range(0, 16));
	endfunction

	function automatic address_t pick_address();
		address_t a;
		a = address_t'($urandom);
		case ($urandom_range(0, 9))
			0, 1: ;
			2, 3, 4: a[12] = 1'b1;
			5: a = {1'b1, HOT_SLICE_LO + 12'($urandom_range(0, 31))};
			6: a = {1'b1, 12'($urandom_range(0, 12'h1FF))};
			7, 8: begin
				a[12] = 1'b0;
				a[9] = 1'b0;
				a[7] = 1'b1;
			end
			default: begin
				a[12] = 1'b0;
				a[7] = 1'b0;
			end
		endcase
		return a;
	endfunction

	task automatic queue_access(action_t act, address_t addr, data_t d, image_idx_t ii);
		store_t st;
		int idx;
		logic hot;
		bus_entry_t e;
		st = route(gen_mode, gen_sc, gen_bank, gen_slices, act, addr, idx, hot);
		if (act == ACT_READ) begin
			if (st == ST_IMAGE && !img_known[idx])
				queue_access(ACT_LOAD, address_t'($urandom), data_t'($urandom),
					image_idx_t'(idx));
			else if (st == ST_CONSOLE && !con_known[idx])
				queue_access(ACT_WRITE, addr, data_t'($urandom), ii);
			else if (st == ST_CART && !crt_known[idx])
				queue_access(ACT_WRITE, {1'b1, 12'(idx)}, data_t'($urandom), ii);
		end
		if (act == ACT_LOAD)
			img_known[ii] = 1'b1;
		else if (act == ACT_WRITE && st == ST_CONSOLE)
			con_known[idx] = 1'b1;
		else if (act == ACT_WRITE && st == ST_CART)
			crt_known[idx] = 1'b1;
		if (hot)
			apply_hotspot(gen_mode, addr[11:0], gen_bank, gen_slices);
		e = '0;
		e.kind = ENT_ACCESS;
		e.action = act;
		e.address = addr;
		e.data = d;
		e.image_index = ii;
		e.gap = draw_gap();
		bus_requests.push_back(e);
	endtask

	task automatic queue_config(logic [CfgIndexW-1:0] ri, logic [CfgDataW-1:0] v);
		bus_entry_t e;
		if (ri == REG_BANK_MODE)
			gen_mode = mode_t'(v);
		else
			gen_sc = v[0];
		e = '0;
		e.kind = ENT_CONFIG;
		e.reg_index = ri;
		e.reg_value = v;
		bus_requests.push_back(e);
	endtask

	task automatic queue_drain();
		bus_entry_t e;
		e = '0;
		e.kind = ENT_DRAIN;
		bus_requests.push_back(e);
	endtask

	task automatic report_mismatch(string what, int got, int want);
		mismatches++;
		$display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.action = ACT_READ;
		req_ch.address = '0;
		req_ch.data = '0;
		req_ch.image_index = '0;
		rsp_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_BANK_MODE;
		cfg_data = '0;
		forever #5 clk = ~clk;
	end

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			cfg_we <= 1'b0;
			gap_left = 0;
			settle = 0;
			sel_bank = '0;
			sel_slices = '0;
			cfg_mode = MODE_4K;
			cfg_sc = 1'b0;
		end else begin
			logic present;
			logic cfg_go;
			present = 1'b0;
			cfg_go = 1'b0;
			settle = (!req_ch.valid && bus_replies_due.size() == 0) ? settle + 1 : 0;
			if (!req_ch.valid || req_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (bus_requests.size() > 0) begin
					head = bus_requests[0];
					if (head.kind == ENT_ACCESS) begin
						present = 1'b1;
						req_ch.action <= head.action;
						req_ch.address <= head.address;
						req_ch.data <= head.data;
						req_ch.image_index <= head.image_index;
						gap_left = head.gap;
						void'(bus_requests.pop_front());
					end else if (!req_ch.valid && settle >= SETTLE_CYCLES) begin
						if (head.kind == ENT_CONFIG) begin
							cfg_go = 1'b1;
							cfg_index <= head.reg_index;
							cfg_data <= head.reg_value;
							if (head.reg_index == REG_BANK_MODE)
								cfg_mode = mode_t'(head.reg_value);
							else
								cfg_sc = head.reg_value[0];
						end
						void'(bus_requests.pop_front());
					end
				end
				req_ch.valid <= present;
			end
			cfg_we <= cfg_go;
		end
	end

	// reply monitor and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			bus_entry_t got_req;
			bus_reply_t want;
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (bus_replies_due.size() == 0) begin
					report_mismatch("reply with no request outstanding", rsp_ch.read_data, 0);
				end else begin
					want = bus_replies_due.pop_front();
					if (rsp_ch.read_data !== want.read_data)
						report_mismatch("read_data", rsp_ch.read_data, want.read_data);
					if (rsp_ch.passed_on !== want.passed_on)
						report_mismatch("passed_on", rsp_ch.passed_on, want.passed_on);
				end
				replies_seen++;
				stall_left = (replies_seen % 300 >= 220 || $urandom_range(0, 1)) ? 0 :
					$urandom_range(0, 16);
			end
			if (req_ch.valid && req_ch.ready) begin
				got_req = '0;
				got_req.kind = ENT_ACCESS;
				got_req.action = req_ch.action;
				got_req.address = req_ch.address;
				got_req.data = req_ch.data;
				got_req.image_index = req_ch.image_index;
				bus_replies_due.push_back(serve_access(got_req));
			end
			if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		mode_t phase_mode [NUM_PHASES];
		logic phase_sc [NUM_PHASES];
		int r;
		action_t act;
		phase_mode = '{MODE_16K, MODE_8K, MODE_12K, MODE_12K, MODE_SLICED, MODE_SLICED,
			MODE_4K, MODE_UNUSED, MODE_16K, MODE_8K};
		phase_sc = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
		quiet_cycles = 0;
		mismatches = 0;
		replies_seen = 0;
		gen_mode = MODE_4K;
		gen_sc = 1'b0;
		gen_bank = '0;
		gen_slices = '0;
		quiet_sender = 1'b0;

		// directed: fixed 4K, console RAM, passed-on decode, reserved action
		queue_config(REG_BANK_MODE, MODE_4K);
		queue_config(REG_SUPERCHIP, 3'd0);
		queue_access(ACT_LOAD, 13'h0000, 8'h00, 14'h0000);
		queue_access(ACT_LOAD, 13'h1FFF, 8'hFF, 14'h3FFF);
		queue_access(ACT_LOAD, 13'h0000, 8'hA5, 14'h0FFF);
		queue_access(ACT_READ, 13'h1000, 8'hFF, 14'h3FFF);
		queue_access(ACT_READ, 13'h1FFF, 8'h00, 14'h0000);
		queue_access(ACT_WRITE, 13'h0080, 8'hFF, 14'h0000);
		queue_access(ACT_WRITE, 13'h0DFF, 8'h00, 14'h0000);
		queue_access(ACT_READ, 13'h0080, 8'h00, 14'h0000);
		queue_access(ACT_READ, 13'h0DFF, 8'h00, 14'h0000);
		queue_access(ACT_READ, 13'h0000, 8'h00, 14'h0000);
		queue_access(ACT_WRITE, 13'h0FFF, 8'hFF, 14'h0000);
		queue_access(ACT_RESERVED, 13'h1FFF, 8'hFF, 14'h3FFF);
		// 16K with superchip: RAM windows, switch on read and on write
		queue_config(REG_BANK_MODE, MODE_16K);
		queue_config(REG_SUPERCHIP, 3'd1);
		queue_access(ACT_WRITE, 13'h1000, 8'h5A, 14'h0000);
		queue_access(ACT_WRITE, 13'h107F, 8'hC3, 14'h0000);
		queue_access(ACT_READ, 13'h1080, 8'h00, 14'h0000);
		queue_access(ACT_READ, 13'h10FF, 8'h00, 14'h0000);
		queue_access(ACT_READ, 13'h1FF9, 8'h00, 14'h0000);
		queue_access(ACT_READ, 13'h1FFF, 8'h00, 14'h0000);
		queue_access(ACT_READ, 13'h1FF6, 8'h00, 14'h0000);
		queue_access(ACT_WRITE, 13'h1FF7, 8'h00, 14'h0000);
		queue_access(ACT_READ, 13'h1000, 8'h00, 14'h0000);

		for (int p = 0; p < NUM_PHASES; p++) begin
			quiet_sender = (p % 4 == 2);
			queue_config(REG_BANK_MODE, phase_mode[p]);
			queue_config(REG_SUPERCHIP, {2'b00, phase_sc[p]});
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 3 && i == PHASE_ITEMS / 2)
					queue_drain();
				r = $urandom_range(0, 19);
				if (r < 9)
					act = ACT_READ;
				else if (r < 15)
					act = ACT_WRITE;
				else if (r < 19)
					act = ACT_LOAD;
				else
					act = ACT_RESERVED;
				queue_access(act, pick_address(), data_t'($urandom), image_idx_t'($urandom));
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (bus_requests.size() != 0 || req_ch.valid || bus_replies_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES + 4) @(posedge clk);

		$display("covered %0d requests: %0d image loads, %0d image reads, %0d console RAM,",
			replies_seen, n_loads, n_image_reads, n_console);
		$display("%0d cart RAM, %0d passed on, %0d bank switches over all modes",
			n_cart, n_passed, n_switches);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
